[hw/rtl/ompp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ompp_pkg;

	// window geometry
	localparam int HALF_WINDOW = 8;
	localparam int WIN_LEN     = 2 * HALF_WINDOW + 1;
	localparam int VALUE_BITS  = 16;
	localparam int MAX_FRAMES  = 1048576;

	// derived widths
	localparam int FRAME_BITS = $clog2(MAX_FRAMES);
	localparam int IDX_W      = $clog2(WIN_LEN);
	localparam int FILL_W     = $clog2(WIN_LEN + 1);
	localparam int K_W        = $clog2(HALF_WINDOW + 1);
	localparam int REG_W      = 16;
	localparam int POS_W      = 36;
	localparam int SUM_W      = VALUE_BITS + 1;
	localparam int PROD_W     = SUM_W + REG_W;
	localparam int GAIN_FRAC  = 12;
	localparam int CFG_IDX_W  = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_GAP  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_HOP  = CFG_IDX_W'(2);

	// register reset values
	localparam logic [REG_W-1:0] GAIN_RESET = REG_W'(4096);
	localparam logic [REG_W-1:0] GAP_RESET  = REG_W'(1);
	localparam logic [REG_W-1:0] HOP_RESET  = REG_W'(512);

	typedef struct packed {
		logic [15:0] onset_value;
		logic        last_frame;
	} in_item_t;

	typedef struct packed {
		logic [POS_W-1:0] sample_position;
		logic             has_position;
		logic             end_of_stream;
	} out_item_t;

	// controls broadcast to every sort cell
	typedef struct packed {
		logic clr;
		logic ins;
		logic shl;
	} cell_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/ompp_sort_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module ompp_sort_cell
	import ompp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cell_ctl_t             ctl,
	input  wire logic [VALUE_BITS-1:0] x,
	input  wire logic [VALUE_BITS-1:0] left_val,
	input  wire logic                  left_valid,
	input  wire logic [VALUE_BITS-1:0] right_val,
	input  wire logic                  right_valid,
	output logic      [VALUE_BITS-1:0] val,
	output logic                       valid
);

	logic left_big;
	logic take;

	// an empty neighbor counts as larger than anything
	assign left_big = !left_valid || (left_val > x);
	assign take     = ctl.ins && (!valid || (val > x));

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else if (ctl.clr) begin
			valid <= 1'b0;
		end else if (take) begin
			valid <= left_big ? left_valid : 1'b1;
		end else if (ctl.shl) begin
			valid <= right_valid;
		end
	end

	// value: insert from left, or shift toward the head
	always_ff @(posedge clk) begin
		if (take) begin
			val <= left_big ? left_val : x;
		end else if (ctl.shl) begin
			val <= right_val;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/ompp_sort_chain.sv]
`timescale 1ns / 1ps
`default_nettype none

module ompp_sort_chain
	import ompp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cell_ctl_t             ctl,
	input  wire logic [VALUE_BITS-1:0] x,
	output logic      [VALUE_BITS-1:0] head0_val,
	output logic      [VALUE_BITS-1:0] head1_val
);

	logic [VALUE_BITS-1:0] val   [WIN_LEN];
	logic                  valid [WIN_LEN];
	logic [VALUE_BITS-1:0] lval  [WIN_LEN];
	logic                  lvld  [WIN_LEN];
	logic [VALUE_BITS-1:0] rval  [WIN_LEN];
	logic                  rvld  [WIN_LEN];

	// neighbor wiring, ascending order from the head
	for (genvar i = 0; i < WIN_LEN; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign lval[i] = '0;
			assign lvld[i] = 1'b1;
		end else begin : g_left
			assign lval[i] = val[i-1];
			assign lvld[i] = valid[i-1];
		end
		if (i == WIN_LEN - 1) begin : g_last
			assign rval[i] = '0;
			assign rvld[i] = 1'b0;
		end else begin : g_right
			assign rval[i] = val[i+1];
			assign rvld[i] = valid[i+1];
		end

		ompp_sort_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.x           (x),
			.left_val    (lval[i]),
			.left_valid  (lvld[i]),
			.right_val   (rval[i]),
			.right_valid (rvld[i]),
			.val         (val[i]),
			.valid       (valid[i])
		);
	end

	assign head0_val = val[0];
	assign head1_val = val[1];

endmodule

`default_nettype wire

[hw/rtl/onset_median_peak_picker.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel  | direction | handshake              | payload
// in       | input     | in_valid / in_ready    | in_data  (onset_value, last_frame)
// out      | output    | out_valid / out_ready  | out_data (sample_position, has_position,
//          |           |                        |           end_of_stream)
// cfg      | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One frame at a time. Each decision clears the sorting cell chain, loads window entries
// 0 to hi into it one per cycle, then shifts the median to the head. A plain frame makes
// at most one decision; the final frame makes up to nine decisions.
// Reset clears the window, counters and registers to their defaults.
// A stalled output holds the sequencer only when a further result must be written.

module onset_median_peak_picker
	import ompp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire in_item_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output out_item_t                 out_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [REG_W-1:0]     cfg_data
);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_CHECK = 9'b000000010,
		ST_LOAD  = 9'b000000100,
		ST_ALIGN = 9'b000001000,
		ST_MED   = 9'b000010000,
		ST_DEC   = 9'b000100000,
		ST_PICK  = 9'b001000000,
		ST_STEP  = 9'b010000000,
		ST_FIN   = 9'b100000000
	} state_t;

	state_t                  state_q;
	logic [REG_W-1:0]        gain_q, gap_q, hop_q;
	logic [VALUE_BITS-1:0]   win_q [WIN_LEN];
	logic [FILL_W-1:0]       fill_q;
	logic [FRAME_BITS-1:0]   frame_cnt_q, cur_q, last_pick_q, d_q;
	logic                    pick_valid_q, last_q;
	logic [K_W-1:0]          k_q;
	logic [IDX_W-1:0]        idx_q, hi_q, end_q, sh_q;
	logic [VALUE_BITS-1:0]   v_q, prev_q, next_q;
	logic [PROD_W-1:0]       prod_q;
	logic                    pend_valid_q;
	logic [POS_W-1:0]        pend_pos_q;
	logic                    out_valid_q;
	out_item_t               out_q;

	logic                    can_push;
	logic                    out_wr;
	out_item_t               out_next;
	cell_ctl_t               ctl;
	logic [VALUE_BITS-1:0]   head0, head1;
	logic [SUM_W-1:0]        med_sum;
	logic [FRAME_BITS-1:0]   d_cur, gap_diff;
	logic [REG_W-1:0]        gap_eff;
	logic [IDX_W-1:0]        k_ext, k_hi, fill_m1, hi_c, end_c;
	logic                    pick;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign can_push  = !out_valid_q || out_ready;

	// decision geometry
	assign k_ext   = IDX_W'(k_q);
	assign k_hi    = k_ext + IDX_W'(HALF_WINDOW);
	assign fill_m1 = IDX_W'(fill_q - FILL_W'(1));
	assign hi_c    = (k_hi < fill_m1) ? k_hi : fill_m1;
	assign end_c   = (hi_c > k_ext + IDX_W'(1)) ? hi_c : k_ext + IDX_W'(1);

	// sorting chain
	always_comb begin
		ctl     = '0;
		ctl.clr = (state_q == ST_CHECK);
		ctl.ins = (state_q == ST_LOAD) && (idx_q <= hi_q);
		ctl.shl = (state_q == ST_ALIGN) && (sh_q != '0);
	end

	ompp_sort_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.x         (win_q[idx_q]),
		.head0_val (head0),
		.head1_val (head1)
	);

	// median times two: middle pair for an even count
	assign med_sum = SUM_W'(head0) + (hi_q[0] ? SUM_W'(head1) : SUM_W'(head0));

	// pick decision
	assign d_cur    = cur_q - FRAME_BITS'(k_q);
	assign gap_eff  = (gap_q == '0) ? REG_W'(1) : gap_q;
	assign gap_diff = d_cur - last_pick_q;
	assign pick     = ((PROD_W'(v_q) << (GAIN_FRAC + 1)) > prod_q)
	                  && (v_q >= prev_q) && (v_q >= next_q)
	                  && !(pick_valid_q && (gap_diff < FRAME_BITS'(gap_eff)));

	// output register writes
	always_comb begin
		out_wr   = 1'b0;
		out_next = '0;
		case (state_q)
			ST_PICK: begin
				out_wr                   = pend_valid_q && can_push;
				out_next.sample_position = pend_pos_q;
				out_next.has_position    = 1'b1;
			end
			ST_FIN: begin
				out_wr                   = can_push && (last_q || pend_valid_q);
				out_next.sample_position = pend_valid_q ? pend_pos_q : '0;
				out_next.has_position    = pend_valid_q;
				out_next.end_of_stream   = last_q;
			end
			default: begin
				out_wr = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_wr) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_wr) begin
			out_q <= out_next;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
			gap_q  <= GAP_RESET;
			hop_q  <= HOP_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_GAIN: gain_q <= cfg_data;
				REG_GAP:  gap_q  <= cfg_data;
				REG_HOP:  hop_q  <= cfg_data;
				default:  gain_q <= gain_q;
			endcase
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_CHECK: begin
				hi_q   <= hi_c;
				end_q  <= end_c;
				idx_q  <= '0;
				next_q <= '0;
			end
			ST_LOAD: begin
				if (idx_q == k_ext) begin
					v_q <= win_q[idx_q];
				end
				if (idx_q == k_ext + IDX_W'(1)) begin
					prev_q <= win_q[idx_q];
				end
				if ((k_q != '0) && (idx_q == k_ext - IDX_W'(1))) begin
					next_q <= win_q[idx_q];
				end
				idx_q <= idx_q + IDX_W'(1);
				sh_q  <= hi_q >> 1;
			end
			ST_ALIGN: begin
				if (sh_q != '0) begin
					sh_q <= sh_q - IDX_W'(1);
				end
			end
			ST_MED: begin
				prod_q <= PROD_W'(med_sum) * PROD_W'(gain_q);
			end
			ST_DEC: begin
				d_q <= d_cur;
			end
			ST_PICK: begin
				if (!pend_valid_q || can_push) begin
					pend_pos_q <= POS_W'(d_q) * POS_W'(hop_q);
				end
			end
			default: begin
				if (in_valid && in_ready) begin
					pend_pos_q <= '0;
				end
			end
		endcase
	end

	// sequencer and stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			for (int i = 0; i < WIN_LEN; i++) begin
				win_q[i] <= '0;
			end
			fill_q       <= '0;
			frame_cnt_q  <= '0;
			cur_q        <= '0;
			last_pick_q  <= '0;
			pick_valid_q <= 1'b0;
			last_q       <= 1'b0;
			k_q          <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						for (int i = WIN_LEN - 1; i > 0; i--) begin
							win_q[i] <= win_q[i-1];
						end
						win_q[0] <= in_data.onset_value[VALUE_BITS-1:0];
						if (fill_q != FILL_W'(WIN_LEN)) begin
							fill_q <= fill_q + FILL_W'(1);
						end
						if (frame_cnt_q != FRAME_BITS'(MAX_FRAMES - 1)) begin
							frame_cnt_q <= frame_cnt_q + FRAME_BITS'(1);
						end
						cur_q        <= frame_cnt_q;
						last_q       <= in_data.last_frame;
						k_q          <= K_W'(HALF_WINDOW);
						pend_valid_q <= (frame_cnt_q == '0);
						state_q      <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= (cur_q > FRAME_BITS'(k_q)) ? ST_LOAD : ST_STEP;
				end
				ST_LOAD: begin
					if (idx_q == end_q) begin
						state_q <= ST_ALIGN;
					end
				end
				ST_ALIGN: begin
					if (sh_q == '0) begin
						state_q <= ST_MED;
					end
				end
				ST_MED: begin
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					if (pick) begin
						last_pick_q  <= d_cur;
						pick_valid_q <= 1'b1;
						state_q      <= ST_PICK;
					end else begin
						state_q <= ST_STEP;
					end
				end
				ST_PICK: begin
					if (!pend_valid_q || can_push) begin
						pend_valid_q <= 1'b1;
						state_q      <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (last_q && (k_q != '0)) begin
						k_q     <= k_q - K_W'(1);
						state_q <= ST_CHECK;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!last_q && !pend_valid_q) begin
						state_q <= ST_IDLE;
					end else if (can_push) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
						if (last_q) begin
							for (int i = 0; i < WIN_LEN; i++) begin
								win_q[i] <= '0;
							end
							fill_q       <= '0;
							frame_cnt_q  <= '0;
							last_pick_q  <= '0;
							pick_valid_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WIN_LEN))
		else $error("window fill beyond window length");

	a_frame_bound: assert property (@(posedge clk) disable iff (!arst_n)
		frame_cnt_q <= FRAME_BITS'(MAX_FRAMES - 1))
		else $error("frame counter past saturation");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && last_q && can_push)
		|=> (frame_cnt_q == '0 && fill_q == '0 && !pick_valid_q && !pend_valid_q))
		else $error("stream state not cleared after flush");

	a_median_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MED && hi_q[0]) |-> (head0 <= head1))
		else $error("middle pair out of order");

endmodule

`default_nettype wire
